// ===== rtl/fmc_pkg.sv =====
// Shared types and constants for the filtered mean color core.
// Used by fmc_filter, fmc_divider and filtered_mean_color_core; depends on nothing.
package fmc_pkg;

   // Field widths.
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned KEPT_W     = 19;
   localparam int unsigned QUO_W      = 8;
   // A channel sum never exceeds 255 times the kept count, so it fits in the
   // count width plus the quotient width less one bit.
   localparam int unsigned SUM_W      = KEPT_W + QUO_W - 1;
   localparam int unsigned MAX_PIXELS = 262144;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned LIGHT_W    = PIX_W + 1;
   localparam int unsigned SAT_W      = 2 * PIX_W + 1;

   // Configuration reset values.
   localparam logic [PIX_W-1:0] MID_LOW_RST   = 8'd70;
   localparam logic [PIX_W-1:0] MID_HIGH_RST  = 8'd180;
   localparam logic [PIX_W-1:0] SAT_MIN_RST   = 8'd150;
   localparam logic [PIX_W-1:0] LIGHT_MIN_RST = 8'd50;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE      = 3'd0,
      CSR_MID_LOW   = 3'd1,
      CSR_MID_HIGH  = 3'd2,
      CSR_SAT_MIN   = 3'd3,
      CSR_LIGHT_MIN = 3'd4
   } csr_index_type;

   // Filter modes.
   typedef enum logic {
      MODE_MID_BRIGHT = 1'b0,
      MODE_SATURATION = 1'b1
   } mode_type;

   // Filter settings as seen by the filter.
   typedef struct packed {
      mode_type         mode;
      logic [PIX_W-1:0] mid_low;
      logic [PIX_W-1:0] mid_high;
      logic [PIX_W-1:0] saturation_min;
      logic [PIX_W-1:0] lightness_min;
   } cfg_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILTER,
      ST_DIV_LOAD,
      ST_DIV_RUN
   } state_type;

   // Channel being divided.
   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

endpackage

// ===== rtl/fmc_filter.sv =====
// Pixel filter: decides whether one pixel is kept under the current settings.
// Depends on fmc_pkg.
module fmc_filter (
   input  fmc_pkg::cfg_type               cfg,
   input  logic [fmc_pkg::PIX_W-1:0]      red,
   input  logic [fmc_pkg::PIX_W-1:0]      green,
   input  logic [fmc_pkg::PIX_W-1:0]      blue,
   output logic                           keep
);

   logic [fmc_pkg::PIX_W+1:0]   sum3;
   logic [fmc_pkg::PIX_W+1:0]   low3;
   logic [fmc_pkg::PIX_W+1:0]   high3;
   logic                        mid_ok;
   logic [fmc_pkg::PIX_W-1:0]   hi;
   logic [fmc_pkg::PIX_W-1:0]   lo;
   logic [fmc_pkg::PIX_W-1:0]   spread;
   logic [fmc_pkg::SAT_W-1:0]   sat_lhs;
   logic [fmc_pkg::SAT_W-1:0]   sat_rhs;
   logic                        sat_ok;
   logic [fmc_pkg::LIGHT_W-1:0] light_sum;
   logic                        light_ok;

   // Mid-brightness: floor(sum/3) lies in [low, high] exactly when
   // 3*low <= sum < 3*high + 3.
   always_comb begin
      sum3   = (fmc_pkg::PIX_W+2)'(red) + (fmc_pkg::PIX_W+2)'(green)
             + (fmc_pkg::PIX_W+2)'(blue);
      low3   = (fmc_pkg::PIX_W+2)'(cfg.mid_low) * (fmc_pkg::PIX_W+2)'(3);
      high3  = (fmc_pkg::PIX_W+2)'(cfg.mid_high) * (fmc_pkg::PIX_W+2)'(3)
             + (fmc_pkg::PIX_W+2)'(3);
      mid_ok = (sum3 >= low3) && (sum3 < high3);
   end

   // Saturation and lightness. The rounded saturation reaches the minimum when
   // 510*(max-min) + max >= 2*max*minimum, which needs no division.
   always_comb begin
      hi = red;
      lo = red;
      if (green > hi) begin
         hi = green;
      end
      if (blue > hi) begin
         hi = blue;
      end
      if (green < lo) begin
         lo = green;
      end
      if (blue < lo) begin
         lo = blue;
      end
      spread  = hi - lo;
      sat_lhs = fmc_pkg::SAT_W'(spread) * fmc_pkg::SAT_W'(510) + fmc_pkg::SAT_W'(hi);
      sat_rhs = {fmc_pkg::SAT_W'(cfg.saturation_min) * fmc_pkg::SAT_W'(hi)} << 1;
      // A black pixel has saturation zero.
      if (hi == '0) begin
         sat_ok = (cfg.saturation_min == '0);
      end else begin
         sat_ok = (sat_lhs >= sat_rhs);
      end
      light_sum = fmc_pkg::LIGHT_W'(hi) + fmc_pkg::LIGHT_W'(lo) + fmc_pkg::LIGHT_W'(1);
      light_ok  = (light_sum[fmc_pkg::LIGHT_W-1:1] >= cfg.lightness_min);
   end

   // Select the active filter.
   always_comb begin
      case (cfg.mode)
         fmc_pkg::MODE_MID_BRIGHT: keep = mid_ok;
         fmc_pkg::MODE_SATURATION: keep = sat_ok && light_ok;
         default:                  keep = 1'b0;
      endcase
   end

endmodule

// ===== rtl/fmc_divider.sv =====
// Shared restoring divider: one quotient bit per cycle.
// The quotient is known to fit in eight bits. Depends on fmc_pkg.
module fmc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fmc_pkg::SUM_W-1:0]     dividend,
   input  logic [fmc_pkg::KEPT_W-1:0]    divisor,
   output logic                          done,
   output logic [fmc_pkg::QUO_W-1:0]     quotient
);

   localparam int unsigned STEP_W = $clog2(fmc_pkg::QUO_W);

   logic                        run_ff;
   logic                        run_in;
   logic                        done_ff;
   logic                        done_in;
   logic [STEP_W-1:0]           step_ff;
   logic [STEP_W-1:0]           step_in;
   logic [fmc_pkg::SUM_W-1:0]   rem_ff;
   logic [fmc_pkg::SUM_W-1:0]   rem_in;
   logic [fmc_pkg::SUM_W-1:0]   dsr_ff;
   logic [fmc_pkg::SUM_W-1:0]   dsr_in;
   logic [fmc_pkg::QUO_W-1:0]   quo_ff;
   logic [fmc_pkg::QUO_W-1:0]   quo_in;
   logic                        fits;

   // One compare and subtract per cycle against the shifted divisor.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      fits    = (rem_ff >= dsr_ff);
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(fmc_pkg::QUO_W - 1);
         rem_in  = dividend;
         dsr_in  = {divisor, {(fmc_pkg::QUO_W-1){1'b0}}};
         quo_in  = '0;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsr_ff;
         end
         quo_in  = {quo_ff[fmc_pkg::QUO_W-2:0], fits};
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/filtered_mean_color_core.sv =====
// Top level of the filtered mean color core: configuration, pixel sequencer,
// running sums and the final per-channel division. Depends on fmc_pkg,
// fmc_filter and fmc_divider.
//
//   Channel   Ports                                  Handshake
//   request   req_red/green/blue, req_last_pixel     start high while busy low
//   response  rsp_mean_*, rsp_none_kept,             rsp_valid for one cycle
//             rsp_kept_total
//   config    csr_index, csr_data                    csr_write_en
//
// A pixel is captured in ST_IDLE, then filtered and added in ST_FILTER. The
// last pixel of an image adds three divisions on the shared divider, one per
// channel, and its response is registered when the blue division is done
// (from ST_FILTER when no pixel was kept). Reset is synchronous and restores
// the default filter settings and clears the sums. The receiver cannot stall
// the response.
module filtered_mean_color_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [fmc_pkg::PIX_W-1:0]          req_red,
   input  logic [fmc_pkg::PIX_W-1:0]          req_green,
   input  logic [fmc_pkg::PIX_W-1:0]          req_blue,
   input  logic                               req_last_pixel,
   output logic                               rsp_valid,
   output logic [fmc_pkg::PIX_W-1:0]          rsp_mean_red,
   output logic [fmc_pkg::PIX_W-1:0]          rsp_mean_green,
   output logic [fmc_pkg::PIX_W-1:0]          rsp_mean_blue,
   output logic                               rsp_none_kept,
   output logic [fmc_pkg::KEPT_W-1:0]         rsp_kept_total,
   input  logic                               csr_write_en,
   input  logic [fmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fmc_pkg::PIX_W-1:0]          csr_data
);

   fmc_pkg::cfg_type             cfg_ff;
   fmc_pkg::cfg_type             cfg_in;
   fmc_pkg::state_type           state_ff;
   fmc_pkg::state_type           state_in;
   fmc_pkg::chan_type            ch_ff;
   fmc_pkg::chan_type            ch_in;

   logic [fmc_pkg::PIX_W-1:0]    pix_red_ff;
   logic [fmc_pkg::PIX_W-1:0]    pix_red_in;
   logic [fmc_pkg::PIX_W-1:0]    pix_green_ff;
   logic [fmc_pkg::PIX_W-1:0]    pix_green_in;
   logic [fmc_pkg::PIX_W-1:0]    pix_blue_ff;
   logic [fmc_pkg::PIX_W-1:0]    pix_blue_in;
   logic                         last_ff;
   logic                         last_in;

   logic [fmc_pkg::SUM_W-1:0]    red_sum_ff;
   logic [fmc_pkg::SUM_W-1:0]    red_sum_in;
   logic [fmc_pkg::SUM_W-1:0]    green_sum_ff;
   logic [fmc_pkg::SUM_W-1:0]    green_sum_in;
   logic [fmc_pkg::SUM_W-1:0]    blue_sum_ff;
   logic [fmc_pkg::SUM_W-1:0]    blue_sum_in;
   logic [fmc_pkg::KEPT_W-1:0]   kept_ff;
   logic [fmc_pkg::KEPT_W-1:0]   kept_in;
   logic [fmc_pkg::KEPT_W-1:0]   kept_next;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [fmc_pkg::PIX_W-1:0]    mean_red_ff;
   logic [fmc_pkg::PIX_W-1:0]    mean_red_in;
   logic [fmc_pkg::PIX_W-1:0]    mean_green_ff;
   logic [fmc_pkg::PIX_W-1:0]    mean_green_in;
   logic [fmc_pkg::PIX_W-1:0]    mean_blue_ff;
   logic [fmc_pkg::PIX_W-1:0]    mean_blue_in;
   logic                         none_kept_ff;
   logic                         none_kept_in;
   logic [fmc_pkg::KEPT_W-1:0]   kept_total_ff;
   logic [fmc_pkg::KEPT_W-1:0]   kept_total_in;

   logic                         accept;
   logic                         keep;
   logic                         count_ok;
   logic                         div_start;
   logic                         div_done;
   logic [fmc_pkg::SUM_W-1:0]    div_dividend;
   logic [fmc_pkg::QUO_W-1:0]    div_quotient;

   assign busy   = (state_ff != fmc_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            fmc_pkg::CSR_MODE:      cfg_in.mode           = fmc_pkg::mode_type'(csr_data[0]);
            fmc_pkg::CSR_MID_LOW:   cfg_in.mid_low        = csr_data;
            fmc_pkg::CSR_MID_HIGH:  cfg_in.mid_high       = csr_data;
            fmc_pkg::CSR_SAT_MIN:   cfg_in.saturation_min = csr_data;
            fmc_pkg::CSR_LIGHT_MIN: cfg_in.lightness_min  = csr_data;
            default:                cfg_in                = cfg_ff;
         endcase
      end
   end

   // Pixel filter on the captured pixel.
   fmc_filter u_filter (
      .cfg   (cfg_ff),
      .red   (pix_red_ff),
      .green (pix_green_ff),
      .blue  (pix_blue_ff),
      .keep  (keep)
   );

   // Dividend for the channel under division.
   always_comb begin
      case (ch_ff)
         fmc_pkg::CH_RED:   div_dividend = red_sum_ff;
         fmc_pkg::CH_GREEN: div_dividend = green_sum_ff;
         default:           div_dividend = blue_sum_ff;
      endcase
   end

   // Shared divider for the three channel means.
   fmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (kept_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer: capture, filter and accumulate, then divide on the last pixel.
   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      pix_red_in    = pix_red_ff;
      pix_green_in  = pix_green_ff;
      pix_blue_in   = pix_blue_ff;
      last_in       = last_ff;
      red_sum_in    = red_sum_ff;
      green_sum_in  = green_sum_ff;
      blue_sum_in   = blue_sum_ff;
      kept_in       = kept_ff;
      rsp_valid_in  = 1'b0;
      mean_red_in   = mean_red_ff;
      mean_green_in = mean_green_ff;
      mean_blue_in  = mean_blue_ff;
      none_kept_in  = none_kept_ff;
      kept_total_in = kept_total_ff;
      div_start     = 1'b0;
      count_ok      = (kept_ff < fmc_pkg::KEPT_W'(fmc_pkg::MAX_PIXELS));
      kept_next     = kept_ff;
      if (keep && count_ok) begin
         kept_next = kept_ff + fmc_pkg::KEPT_W'(1);
      end

      case (state_ff)
         fmc_pkg::ST_IDLE: begin
            if (accept) begin
               pix_red_in   = req_red;
               pix_green_in = req_green;
               pix_blue_in  = req_blue;
               last_in      = req_last_pixel;
               state_in     = fmc_pkg::ST_FILTER;
            end
         end
         fmc_pkg::ST_FILTER: begin
            // Add a kept pixel unless the count is already full.
            if (keep && count_ok) begin
               red_sum_in   = red_sum_ff + fmc_pkg::SUM_W'(pix_red_ff);
               green_sum_in = green_sum_ff + fmc_pkg::SUM_W'(pix_green_ff);
               blue_sum_in  = blue_sum_ff + fmc_pkg::SUM_W'(pix_blue_ff);
               kept_in      = kept_next;
            end
            if (!last_ff) begin
               state_in = fmc_pkg::ST_IDLE;
            end else if (kept_next == '0) begin
               // Nothing kept in this image: report zeros at once.
               rsp_valid_in  = 1'b1;
               mean_red_in   = '0;
               mean_green_in = '0;
               mean_blue_in  = '0;
               none_kept_in  = 1'b1;
               kept_total_in = '0;
               state_in      = fmc_pkg::ST_IDLE;
            end else begin
               ch_in    = fmc_pkg::CH_RED;
               state_in = fmc_pkg::ST_DIV_LOAD;
            end
         end
         fmc_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = fmc_pkg::ST_DIV_RUN;
         end
         fmc_pkg::ST_DIV_RUN: begin
            if (div_done) begin
               case (ch_ff)
                  fmc_pkg::CH_RED: begin
                     mean_red_in = div_quotient;
                     ch_in       = fmc_pkg::CH_GREEN;
                     state_in    = fmc_pkg::ST_DIV_LOAD;
                  end
                  fmc_pkg::CH_GREEN: begin
                     mean_green_in = div_quotient;
                     ch_in         = fmc_pkg::CH_BLUE;
                     state_in      = fmc_pkg::ST_DIV_LOAD;
                  end
                  default: begin
                     // Last channel done: report and clear for the next image.
                     mean_blue_in  = div_quotient;
                     none_kept_in  = 1'b0;
                     kept_total_in = kept_ff;
                     rsp_valid_in  = 1'b1;
                     red_sum_in    = '0;
                     green_sum_in  = '0;
                     blue_sum_in   = '0;
                     kept_in       = '0;
                     state_in      = fmc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = fmc_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state, configuration and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= fmc_pkg::ST_IDLE;
         cfg_ff.mode           <= fmc_pkg::MODE_MID_BRIGHT;
         cfg_ff.mid_low        <= fmc_pkg::MID_LOW_RST;
         cfg_ff.mid_high       <= fmc_pkg::MID_HIGH_RST;
         cfg_ff.saturation_min <= fmc_pkg::SAT_MIN_RST;
         cfg_ff.lightness_min  <= fmc_pkg::LIGHT_MIN_RST;
         red_sum_ff            <= '0;
         green_sum_ff          <= '0;
         blue_sum_ff           <= '0;
         kept_ff               <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         state_ff              <= state_in;
         cfg_ff                <= cfg_in;
         red_sum_ff            <= red_sum_in;
         green_sum_ff          <= green_sum_in;
         blue_sum_ff           <= blue_sum_in;
         kept_ff               <= kept_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff         <= ch_in;
      pix_red_ff    <= pix_red_in;
      pix_green_ff  <= pix_green_in;
      pix_blue_ff   <= pix_blue_in;
      last_ff       <= last_in;
      mean_red_ff   <= mean_red_in;
      mean_green_ff <= mean_green_in;
      mean_blue_ff  <= mean_blue_in;
      none_kept_ff  <= none_kept_in;
      kept_total_ff <= kept_total_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_red   = mean_red_ff;
   assign rsp_mean_green = mean_green_ff;
   assign rsp_mean_blue  = mean_blue_ff;
   assign rsp_none_kept  = none_kept_ff;
   assign rsp_kept_total = kept_total_ff;

   // A response is a single-cycle strobe.
   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // An empty image reports zero means and a zero count.
   a_rsp_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_none_kept) |-> (rsp_kept_total == '0 && rsp_mean_red == '0
         && rsp_mean_green == '0 && rsp_mean_blue == '0))
      else $error("empty image reported nonzero fields");

   // A non-empty image reports a count within range.
   a_rsp_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_none_kept) |-> (rsp_kept_total != '0
         && rsp_kept_total <= fmc_pkg::KEPT_W'(fmc_pkg::MAX_PIXELS)))
      else $error("kept count out of range");

   // An accepted request makes the block busy.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

endmodule

// ===== verif/fmc_mean_checker.sv =====
// Checker for filtered_mean_color_core: mirrors the filter settings and running
// sums from the observed requests and register writes, and compares each response.
// Depends on fmc_pkg.
module fmc_mean_checker
   import fmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [PIX_W-1:0]     req_red,
   input  logic [PIX_W-1:0]     req_green,
   input  logic [PIX_W-1:0]     req_blue,
   input  logic                 req_last_pixel,
   input  logic                 rsp_valid,
   input  logic [PIX_W-1:0]     rsp_mean_red,
   input  logic [PIX_W-1:0]     rsp_mean_green,
   input  logic [PIX_W-1:0]     rsp_mean_blue,
   input  logic                 rsp_none_kept,
   input  logic [KEPT_W-1:0]    rsp_kept_total,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PIX_W-1:0]     csr_data,
   output int unsigned          error_count,
   output int unsigned          pending_images,
   output int unsigned          images_checked
);

   localparam logic [KEPT_W-1:0] KEPT_LIMIT = KEPT_W'(MAX_PIXELS);

   // Mean color of one finished image.
   typedef struct {
      logic [PIX_W-1:0]  mean_red;
      logic [PIX_W-1:0]  mean_green;
      logic [PIX_W-1:0]  mean_blue;
      logic              none_kept;
      logic [KEPT_W-1:0] kept_total;
   } image_mean_type;

   image_mean_type    expected_means[$];
   cfg_type           filter_cfg;
   logic [SUM_W-1:0]  red_acc;
   logic [SUM_W-1:0]  green_acc;
   logic [SUM_W-1:0]  blue_acc;
   logic [KEPT_W-1:0] kept_count;
   int unsigned       mismatches = 0;
   int unsigned       checked = 0;

   // Decide whether a pixel passes the selected filter.
   function automatic logic pixel_kept(input cfg_type cfg, input logic [PIX_W-1:0] r,
                                       input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
      int unsigned rc, gc, bc, hi, lo, avg, sat, light;
      rc = 32'(r);
      gc = 32'(g);
      bc = 32'(b);
      if (cfg.mode == MODE_MID_BRIGHT) begin
         avg = (rc + gc + bc) / 3;
         return avg >= 32'(cfg.mid_low) && avg <= 32'(cfg.mid_high);
      end
      hi = rc;
      lo = rc;
      if (gc > hi) hi = gc;
      if (bc > hi) hi = bc;
      if (gc < lo) lo = gc;
      if (bc < lo) lo = bc;
      // A black pixel has no hue, so its saturation counts as zero.
      if (hi == 0) sat = 0;
      else sat = (2 * 255 * (hi - lo) + hi) / (2 * hi);
      light = (hi + lo + 1) / 2;
      return sat >= 32'(cfg.saturation_min) && light >= 32'(cfg.lightness_min);
   endfunction

   // Compare one response field and log a mismatch.
   task automatic check_field(input string field, input logic [KEPT_W-1:0] want,
                              input logic [KEPT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: image %0d %s expected %0d, actual %0d", $time, checked, field,
                  want, got);
      end
   endtask

   always @(posedge clock) begin
      image_mean_type want;
      if (reset) begin
         filter_cfg.mode           = MODE_MID_BRIGHT;
         filter_cfg.mid_low        = MID_LOW_RST;
         filter_cfg.mid_high       = MID_HIGH_RST;
         filter_cfg.saturation_min = SAT_MIN_RST;
         filter_cfg.lightness_min  = LIGHT_MIN_RST;
         red_acc    = '0;
         green_acc  = '0;
         blue_acc   = '0;
         kept_count = '0;
         expected_means.delete();
      end else begin
         // Responses are checked against the oldest finished image.
         if (rsp_valid) begin
            if (expected_means.size() == 0) begin
               mismatches++;
               $display("%0t: response with no image pending, actual %0d %0d %0d %0d %0d",
                        $time, rsp_mean_red, rsp_mean_green, rsp_mean_blue,
                        rsp_none_kept, rsp_kept_total);
            end else begin
               want = expected_means.pop_front();
               check_field("mean_red", KEPT_W'(want.mean_red), KEPT_W'(rsp_mean_red));
               check_field("mean_green", KEPT_W'(want.mean_green), KEPT_W'(rsp_mean_green));
               check_field("mean_blue", KEPT_W'(want.mean_blue), KEPT_W'(rsp_mean_blue));
               check_field("none_kept", KEPT_W'(want.none_kept), KEPT_W'(rsp_none_kept));
               check_field("kept_total", want.kept_total, rsp_kept_total);
               checked++;
            end
         end

         // Register writes; unused indexes change nothing.
         if (csr_write_en) begin
            case (csr_index)
               CSR_MODE:      filter_cfg.mode = mode_type'(csr_data[0]);
               CSR_MID_LOW:   filter_cfg.mid_low = csr_data;
               CSR_MID_HIGH:  filter_cfg.mid_high = csr_data;
               CSR_SAT_MIN:   filter_cfg.saturation_min = csr_data;
               CSR_LIGHT_MIN: filter_cfg.lightness_min = csr_data;
               default: ;
            endcase
         end

         // Accepted pixel: accumulate until the count is full, close the image on last.
         if (start && !busy) begin
            if (pixel_kept(filter_cfg, req_red, req_green, req_blue) &&
                kept_count < KEPT_LIMIT) begin
               red_acc    = red_acc + SUM_W'(req_red);
               green_acc  = green_acc + SUM_W'(req_green);
               blue_acc   = blue_acc + SUM_W'(req_blue);
               kept_count = kept_count + KEPT_W'(1);
            end
            if (req_last_pixel) begin
               if (kept_count == '0) begin
                  want.mean_red   = '0;
                  want.mean_green = '0;
                  want.mean_blue  = '0;
                  want.none_kept  = 1'b1;
                  want.kept_total = '0;
               end else begin
                  want.mean_red   = PIX_W'(red_acc / SUM_W'(kept_count));
                  want.mean_green = PIX_W'(green_acc / SUM_W'(kept_count));
                  want.mean_blue  = PIX_W'(blue_acc / SUM_W'(kept_count));
                  want.none_kept  = 1'b0;
                  want.kept_total = kept_count;
               end
               expected_means.push_back(want);
               red_acc    = '0;
               green_acc  = '0;
               blue_acc   = '0;
               kept_count = '0;
            end
         end
      end
      error_count    <= mismatches;
      pending_images <= expected_means.size();
      images_checked <= checked;
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for filtered_mean_color_core: drives pixels and register writes
// and reports the verdict. Depends on fmc_pkg, fmc_mean_checker and the core.
module tb;
   import fmc_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_PIXELS  = 180;
   localparam int unsigned CSR_SLOTS     = 1 << CSR_IDX_W;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [PIX_W-1:0]     req_red = '0;
   logic [PIX_W-1:0]     req_green = '0;
   logic [PIX_W-1:0]     req_blue = '0;
   logic                 req_last_pixel = 1'b0;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODE;
   logic [PIX_W-1:0]     csr_data = '0;
   logic                 busy;
   logic                 rsp_valid;
   logic [PIX_W-1:0]     rsp_mean_red;
   logic [PIX_W-1:0]     rsp_mean_green;
   logic [PIX_W-1:0]     rsp_mean_blue;
   logic                 rsp_none_kept;
   logic [KEPT_W-1:0]    rsp_kept_total;
   int unsigned          error_count;
   int unsigned          pending_images;
   int unsigned          images_checked;
   int unsigned          pixels_sent = 0;
   int unsigned          quiet_cycles = 0;
   bit                   steady = 1'b0;

   filtered_mean_color_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_mean_red   (rsp_mean_red),
      .rsp_mean_green (rsp_mean_green),
      .rsp_mean_blue  (rsp_mean_blue),
      .rsp_none_kept  (rsp_none_kept),
      .rsp_kept_total (rsp_kept_total),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   fmc_mean_checker mean_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_last_pixel (req_last_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_mean_red   (rsp_mean_red),
      .rsp_mean_green (rsp_mean_green),
      .rsp_mean_blue  (rsp_mean_blue),
      .rsp_none_kept  (rsp_none_kept),
      .rsp_kept_total (rsp_kept_total),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .error_count    (error_count),
      .pending_images (pending_images),
      .images_checked (images_checked)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no request or response for %0d cycles", $time, quiet_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one pixel request and hold it until the core takes it.
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b, input logic last);
      req_red        <= r;
      req_green      <= g;
      req_blue       <= b;
      req_last_pixel <= last;
      start          <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixels_sent++;
      if (!steady && $urandom_range(99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every finished image has been answered.
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_images != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write every register slot in one burst; unused slots get random data.
   task automatic load_filter(input mode_type m, input logic [PIX_W-1:0] lo,
                              input logic [PIX_W-1:0] hi, input logic [PIX_W-1:0] sat,
                              input logic [PIX_W-1:0] light);
      logic [PIX_W-1:0] word;
      logic [PIX_W-1:0] mode_word;
      mode_word    = PIX_W'($urandom);
      mode_word[0] = m;
      csr_write_en <= 1'b1;
      for (int i = 0; i < CSR_SLOTS; i++) begin
         case (i)
            CSR_MODE:      word = mode_word;
            CSR_MID_LOW:   word = lo;
            CSR_MID_HIGH:  word = hi;
            CSR_SAT_MIN:   word = sat;
            CSR_LIGHT_MIN: word = light;
            default:       word = PIX_W'($urandom);
         endcase
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= word;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Channel value biased toward the ends of the range.
   function automatic logic [PIX_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   initial begin
      logic [PIX_W-1:0] lo_bound;
      logic [PIX_W-1:0] hi_bound;
      logic [PIX_W-1:0] r;
      logic [PIX_W-1:0] g;
      logic [PIX_W-1:0] b;
      int unsigned      image_len;
      int unsigned      phase_pixels;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default band: a lone black pixel keeps nothing, then band edges.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd70, 8'd70, 8'd70, 1'b0);
      send_pixel(8'd180, 8'd180, 8'd180, 1'b0);
      send_pixel(8'd181, 8'd181, 8'd181, 1'b0);
      send_pixel(8'd69, 8'd69, 8'd70, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
      wait_drained();

      // An inverted band keeps no pixel at all.
      load_filter(MODE_MID_BRIGHT, 8'd200, 8'd100, SAT_MIN_RST, LIGHT_MIN_RST);
      send_pixel(8'd200, 8'd200, 8'd200, 1'b0);
      send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
      send_pixel(8'd150, 8'd150, 8'd150, 1'b1);
      wait_drained();

      // Band pinned at the top, then at the bottom.
      load_filter(MODE_MID_BRIGHT, 8'd255, 8'd255, SAT_MIN_RST, LIGHT_MIN_RST);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd254, 1'b1);
      wait_drained();
      load_filter(MODE_MID_BRIGHT, 8'd0, 8'd0, SAT_MIN_RST, LIGHT_MIN_RST);
      send_pixel(8'd1, 8'd1, 8'd0, 1'b0);
      send_pixel(8'd2, 8'd1, 8'd0, 1'b1);
      wait_drained();

      // Saturation mode with zero thresholds keeps a black pixel too.
      load_filter(MODE_SATURATION, MID_LOW_RST, MID_HIGH_RST, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      wait_drained();

      // Full saturation required, then full saturation and lightness.
      load_filter(MODE_SATURATION, MID_LOW_RST, MID_HIGH_RST, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd1, 1'b0);
      send_pixel(8'd10, 8'd10, 8'd10, 1'b1);
      wait_drained();
      load_filter(MODE_SATURATION, MID_LOW_RST, MID_HIGH_RST, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
      wait_drained();

      // Random images under a series of filter settings.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         steady = (p == 2);
         if (p == 0) begin
            load_filter(MODE_MID_BRIGHT, MID_LOW_RST, MID_HIGH_RST, SAT_MIN_RST,
                        LIGHT_MIN_RST);
         end else if (p == 1) begin
            load_filter(MODE_SATURATION, MID_LOW_RST, MID_HIGH_RST, SAT_MIN_RST,
                        LIGHT_MIN_RST);
         end else begin
            lo_bound = PIX_W'($urandom_range(200));
            if ($urandom_range(3) == 0) hi_bound = PIX_W'($urandom);
            else hi_bound = PIX_W'(lo_bound + $urandom_range(55));
            load_filter(p[0] ? MODE_SATURATION : MODE_MID_BRIGHT, lo_bound, hi_bound,
                        PIX_W'($urandom_range(200)), PIX_W'($urandom_range(160)));
         end
         phase_pixels = 0;
         while (phase_pixels < PHASE_PIXELS) begin
            if ($urandom_range(9) == 0) image_len = $urandom_range(64, 17);
            else image_len = $urandom_range(16, 1);
            for (int k = 0; k < image_len; k++) begin
               r = random_channel();
               g = random_channel();
               b = random_channel();
               if ($urandom_range(7) == 0) begin
                  g = r;
                  b = r;
               end
               send_pixel(r, g, b, k == image_len - 1);
            end
            phase_pixels += image_len;
            // Let the core run dry once in the middle of a phase.
            if (p == 3 && phase_pixels == image_len) wait_drained();
         end
         wait_drained();
      end

      $display("Run covered %0d pixels in %0d answered images under %0d filter settings,",
               pixels_sent, images_checked, RANDOM_PHASES + 7);
      $display("both modes, band and threshold extremes, and empty images.");
      if (error_count == 0 && pending_images == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
